// ===== hw/rtl/tti_pkg.sv =====
// Shared types and constants of the thermistor table interpolator.
`timescale 1ns / 1ps
`default_nettype none

package tti_pkg;

    // Table geometry.
    localparam int DEFAULT_TABLE_DEPTH = 128;
    localparam int LEN_W               = 8;

    // Field widths of one input word and one result word.
    localparam int INDEX_W  = 7;
    localparam int RAW_W    = 16;
    localparam int TEMP_W   = 16;
    localparam int RESULT_W = 24;
    localparam int FRAC_W   = 8;

    // Input tdata layout, lowest field first, padded to whole bytes.
    localparam int INDEX_LSB  = 0;
    localparam int ERAW_LSB   = INDEX_LSB + INDEX_W;
    localparam int ETEMP_LSB  = ERAW_LSB + RAW_W;
    localparam int SAMPLE_LSB = ETEMP_LSB + TEMP_W;
    localparam int IN_USED_W  = SAMPLE_LSB + RAW_W;
    localparam int IN_TDATA_W = ((IN_USED_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = RESULT_W;

    // The quotient is produced one bit per divider step.
    localparam int DIV_STEPS = RESULT_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [LEN_W-1:0] LEN_RESET = 8'd2;

    // Word kinds carried in tuser.
    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    // Datapath commands issued by the controller.
    typedef enum logic [3:0] {
        OP_IDLE,
        OP_WRITE,
        OP_INIT,
        OP_PROBE,
        OP_NARROW,
        OP_BOUND,
        OP_SETUP,
        OP_MUL1,
        OP_MUL2,
        OP_PREP,
        OP_DIV,
        OP_FINISH
    } t_op;

    // Datapath status seen by the controller after a probe.
    typedef struct packed {
        logic at_start;
        logic at_end;
        logic below;
        logic above;
        logic flat;
    } t_status;

endpackage

`default_nettype wire

// ===== hw/rtl/tti_datapath.sv =====
// Datapath: table memory, bisection bounds, multiplier and serial divider.
`timescale 1ns / 1ps
`default_nettype none

module tti_datapath #(
    parameter int TABLE_DEPTH = tti_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  tti_pkg::t_op                    i_op,
    input  logic                            i_cfg_wen,
    input  logic [tti_pkg::LEN_W-1:0]       i_cfg_wdata,
    input  logic [tti_pkg::IN_TDATA_W-1:0]  i_tdata,
    output tti_pkg::t_status                o_status,
    output logic [tti_pkg::RESULT_W-1:0]    o_result
);
    import tti_pkg::*;

    localparam int AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int ENTRY_W = RAW_W + TEMP_W;
    localparam int PROD1_W = TEMP_W + RAW_W + 1;
    localparam int PROD2_W = RAW_W + TEMP_W + 2;
    localparam int SUM_W   = PROD2_W + 1;
    localparam int NUM_W   = SUM_W + FRAC_W;
    localparam int REM_W   = RAW_W;
    localparam logic [LEN_W-1:0]    DEPTH_L = LEN_W'(TABLE_DEPTH);
    localparam logic [RESULT_W-1:0] QUO_MAX = {1'b1, {(RESULT_W - 1){1'b0}}};

    // Each entry holds the raw reading in the upper half, the temperature below.
    logic [ENTRY_W-1:0] mem [TABLE_DEPTH];

    logic [LEN_W-1:0]          r_table_length;
    logic [LEN_W-1:0]          r_lo;
    logic [LEN_W-1:0]          r_hi;
    logic [LEN_W-1:0]          r_mid;
    logic [LEN_W-1:0]          r_len;
    logic signed [RAW_W-1:0]   r_sample;
    logic                      r_at_start;
    logic                      r_at_end;
    logic [ENTRY_W-1:0]        r_rd_a;
    logic [ENTRY_W-1:0]        r_rd_b;
    logic [RAW_W-1:0]          r_d;
    logic [RAW_W-1:0]          r_dx;
    logic signed [TEMP_W:0]    r_dt;
    logic signed [TEMP_W-1:0]  r_t0;
    logic signed [PROD1_W-1:0] r_p1;
    logic signed [PROD2_W-1:0] r_p2;
    logic                      r_neg;
    logic [REM_W-1:0]          r_rem;
    logic [RESULT_W-1:0]       r_quo;
    logic [RESULT_W-1:0]       r_result;

    logic [INDEX_W-1:0]        w_index;
    logic [LEN_W-1:0]          w_idx_l;
    logic [RAW_W-1:0]          w_eraw;
    logic [TEMP_W-1:0]         w_etemp;
    logic signed [RAW_W-1:0]   w_sample;
    logic                      w_write_ok;
    logic [LEN_W-1:0]          w_len_eff;
    logic [LEN_W:0]            w_sum_lh;
    logic [LEN_W-1:0]          w_mid;
    logic                      w_mid_zero;
    logic                      w_mid_end;
    logic [LEN_W-1:0]          w_addr_a;
    logic signed [RAW_W-1:0]   w_ra;
    logic signed [RAW_W-1:0]   w_rb;
    logic signed [TEMP_W-1:0]  w_ta;
    logic signed [TEMP_W-1:0]  w_tb;
    logic signed [RAW_W:0]     w_d_full;
    logic signed [RAW_W:0]     w_dx_full;
    logic signed [TEMP_W:0]    w_dt;
    logic signed [SUM_W-1:0]   w_sum;
    logic signed [NUM_W-1:0]   w_num;
    logic [NUM_W-1:0]          w_abs;
    logic [REM_W:0]            w_shift;
    logic [REM_W:0]            w_trial;
    logic                      w_trial_ok;

    // Input word fields.
    assign w_index    = i_tdata[INDEX_LSB +: INDEX_W];
    assign w_idx_l    = LEN_W'(w_index);
    assign w_eraw     = i_tdata[ERAW_LSB +: RAW_W];
    assign w_etemp    = i_tdata[ETEMP_LSB +: TEMP_W];
    assign w_sample   = $signed(i_tdata[SAMPLE_LSB +: RAW_W]);
    assign w_write_ok = (w_idx_l < DEPTH_L);
    assign w_len_eff  = (r_table_length > DEPTH_L) ? DEPTH_L : r_table_length;

    // Bisection midpoint and the read addresses of one probe.
    assign w_sum_lh   = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid      = w_sum_lh[LEN_W:1];
    assign w_mid_zero = (w_mid == '0);
    assign w_mid_end  = (w_mid == r_lo) || (w_mid == r_hi);

    always_comb begin
        if (w_mid_zero) begin
            w_addr_a = '0;
        end else if (w_mid_end) begin
            w_addr_a = r_len - LEN_W'(1);
        end else begin
            w_addr_a = w_mid - LEN_W'(1);
        end
    end

    // Table memory: one write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (i_op == OP_WRITE && w_write_ok) begin
            mem[w_idx_l[AW-1:0]] <= {w_eraw, w_etemp};
        end
        if (i_op == OP_PROBE) begin
            r_rd_a <= mem[w_addr_a[AW-1:0]];
            r_rd_b <= mem[w_mid[AW-1:0]];
        end
    end

    assign w_ra = $signed(r_rd_a[TEMP_W +: RAW_W]);
    assign w_rb = $signed(r_rd_b[TEMP_W +: RAW_W]);
    assign w_ta = $signed(r_rd_a[TEMP_W-1:0]);
    assign w_tb = $signed(r_rd_b[TEMP_W-1:0]);

    assign o_status.at_start = r_at_start;
    assign o_status.at_end   = r_at_end;
    assign o_status.below    = (r_sample < w_ra);
    assign o_status.above    = (r_sample > w_rb);
    assign o_status.flat     = (w_ra == w_rb);

    // Interpolation operands; the bracket guarantees the raw differences are not negative.
    assign w_d_full  = $signed({w_rb[RAW_W-1], w_rb}) - $signed({w_ra[RAW_W-1], w_ra});
    assign w_dx_full = $signed({r_sample[RAW_W-1], r_sample}) - $signed({w_ra[RAW_W-1], w_ra});
    assign w_dt      = $signed({w_tb[TEMP_W-1], w_tb}) - $signed({w_ta[TEMP_W-1], w_ta});

    // Numerator (t0 * d + dx * dt) * 256 and its magnitude.
    assign w_sum = SUM_W'(r_p1) + SUM_W'(r_p2);
    assign w_num = $signed({w_sum, {FRAC_W{1'b0}}});
    assign w_abs = w_num[NUM_W-1] ? NUM_W'(-w_num) : NUM_W'(w_num);

    // One restoring divider step.
    assign w_shift    = {r_rem, r_quo[RESULT_W-1]};
    assign w_trial    = w_shift - {1'b0, r_d};
    assign w_trial_ok = !w_trial[REM_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_length <= LEN_RESET;
            r_lo           <= '0;
            r_hi           <= '0;
        end else begin
            if (i_cfg_wen) begin
                r_table_length <= i_cfg_wdata;
            end
            case (i_op)
                OP_INIT: begin
                    r_lo <= '0;
                    r_hi <= w_len_eff;
                end
                OP_NARROW: begin
                    if (o_status.below) begin
                        r_hi <= r_mid;
                    end else begin
                        r_lo <= r_mid;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_INIT: begin
                r_sample <= w_sample;
                r_len    <= w_len_eff;
            end
            OP_PROBE: begin
                r_mid      <= w_mid;
                r_at_start <= w_mid_zero;
                r_at_end   <= w_mid_end;
            end
            OP_SETUP: begin
                r_d  <= w_d_full[RAW_W-1:0];
                r_dx <= w_dx_full[RAW_W-1:0];
                r_dt <= w_dt;
                r_t0 <= w_ta;
            end
            OP_MUL1: begin
                r_p1 <= PROD1_W'(r_t0) * PROD1_W'($signed({1'b0, r_d}));
            end
            OP_MUL2: begin
                r_p2 <= PROD2_W'($signed({1'b0, r_dx})) * PROD2_W'(r_dt);
            end
            OP_PREP: begin
                r_neg <= w_num[NUM_W-1];
                r_rem <= w_abs[RESULT_W +: REM_W];
                r_quo <= w_abs[RESULT_W-1:0];
            end
            OP_DIV: begin
                r_rem <= w_trial_ok ? w_trial[REM_W-1:0] : w_shift[REM_W-1:0];
                r_quo <= {r_quo[RESULT_W-2:0], w_trial_ok};
            end
            OP_BOUND: begin
                r_result <= {w_ta, {FRAC_W{1'b0}}};
            end
            OP_FINISH: begin
                r_result <= r_neg ? (~r_quo + RESULT_W'(1)) : r_quo;
            end
            default: begin
            end
        endcase
    end

    assign o_result = r_result;

    // The partial remainder stays below the divisor on every step.
    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == OP_DIV) |-> (r_rem < r_d))
        else $error("divider remainder reached the divisor");

    // The search window never turns inside out.
    a_bounds_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lo <= r_hi)
        else $error("bisection bounds crossed");

    // An interpolated magnitude always fits the signed result.
    a_quotient_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == OP_FINISH) |-> (r_quo <= QUO_MAX))
        else $error("interpolated quotient out of range");

endmodule

`default_nettype wire

// ===== hw/rtl/tti_ctrl.sv =====
// Controller: sequences table writes, bisection probes and the interpolation.
`timescale 1ns / 1ps
`default_nettype none

module tti_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_kind,
    output logic             o_in_ready,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    input  tti_pkg::t_status i_status,
    output tti_pkg::t_op     o_op
);
    import tti_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROBE,
        S_CHECK,
        S_MUL1,
        S_MUL2,
        S_PREP,
        S_DIV,
        S_SIGN
    } t_state;

    t_state           r_state;
    t_state           n_state;
    logic             r_out_valid;
    logic             n_out_valid;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             w_slot_free;
    logic             w_single;

    assign w_slot_free = !r_out_valid || i_out_ready;
    // The answer is one stored temperature: outside the table or a flat bracket.
    assign w_single = i_status.at_start || i_status.at_end ||
                      (!i_status.below && !i_status.above && i_status.flat);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid && !i_out_ready;
        o_op        = OP_IDLE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    if (i_in_kind == REQ_LOOKUP) begin
                        o_op    = OP_INIT;
                        n_state = S_PROBE;
                    end else begin
                        o_op = OP_WRITE;
                    end
                end
            end
            S_PROBE: begin
                o_op    = OP_PROBE;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (w_single) begin
                    if (w_slot_free) begin
                        o_op        = OP_BOUND;
                        n_out_valid = 1'b1;
                        n_state     = S_IDLE;
                    end
                end else if (i_status.below || i_status.above) begin
                    o_op    = OP_NARROW;
                    n_state = S_PROBE;
                end else begin
                    o_op    = OP_SETUP;
                    n_state = S_MUL1;
                end
            end
            S_MUL1: begin
                o_op    = OP_MUL1;
                n_state = S_MUL2;
            end
            S_MUL2: begin
                o_op    = OP_MUL2;
                n_state = S_PREP;
            end
            S_PREP: begin
                o_op    = OP_PREP;
                n_count = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_op    = OP_DIV;
                n_count = r_count + CNT_W'(1);
                if (r_count == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_SIGN;
                end
            end
            S_SIGN: begin
                if (w_slot_free) begin
                    o_op        = OP_FINISH;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_count     <= n_count;
        end
    end

    // No word is taken while reset is held.
    assign o_in_ready  = (r_state == S_IDLE) && i_rst_n;
    assign o_out_valid = r_out_valid;

    // A new result never overwrites one that has not been taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((o_op == OP_BOUND) || (o_op == OP_FINISH)) |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten while full");

    // The divider runs exactly its step count.
    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_count < CNT_W'(DIV_STEPS)))
        else $error("divider step count overran");

    // An accepted lookup always starts with a probe.
    a_lookup_probes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && (i_in_kind == REQ_LOOKUP)) |=> (r_state == S_PROBE))
        else $error("lookup did not start a probe");

endmodule

`default_nettype wire

// ===== hw/rtl/thermistor_table_interpolator.sv =====
// Top level of the thermistor table interpolator: ports, controller and datapath.
`timescale 1ns / 1ps
`default_nettype none

// Converts raw thermistor readings into temperatures by table lookup. Write words
// (tuser = 0) load one (raw, temperature) pair into the table. Lookup words (tuser = 1)
// bisect the first table_length entries, which must be sorted by ascending raw reading,
// and return the linearly interpolated temperature as a signed value with 8 fraction
// bits, truncated toward zero. A sample below the table returns the first temperature,
// one above it the last, and a bracket of two equal raw readings returns the lower
// entry's temperature. Each bisection probe is a read through the two read ports of
// the table memory, then a compare; a lookup makes at most ceil(log2(table_length)) + 1
// probes. A lookup that ends on a table edge or a flat bracket returns the stored
// temperature from its last compare, with no multiply or divide. An interpolated lookup
// makes at most ceil(log2(table_length)) probes and then runs two multiplies, a divider
// load, the 24 steps of the bit-serial divider and a sign step; the divider dominates.
// One word is worked on at a time. A finished result waits in the output register while
// the next word is already accepted; if that next lookup finishes while the register is
// still full, it holds in its last cycle until the result is taken. table_length is to
// be written through i_cfg_wen and i_cfg_wdata only while the block is idle; the block
// itself does not enforce this. Values above TABLE_DEPTH use the whole table. Table
// entries have no reset value and must be written before a lookup can reach them.
module thermistor_table_interpolator #(
    parameter int TABLE_DEPTH = tti_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration: table_length.
    input  logic                              i_cfg_wen,
    input  logic [tti_pkg::LEN_W-1:0]         i_cfg_wdata,
    // Input words.
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // tdata, lowest bit up: entry_index[6:0], entry_raw[22:7], entry_temp[38:23],
    // raw_sample[54:39], zero pad[55].
    input  logic [tti_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    // tuser: req_type[0] (0 writes an entry, 1 looks up a sample).
    input  logic                              i_s_axis_tuser,
    // Result words.
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // tdata, lowest bit up: temperature_q8[23:0].
    output logic [tti_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata
);
    import tti_pkg::*;

    t_op     w_op;
    t_status w_status;

    // The controller owns the handshakes and issues one datapath command per cycle.
    tti_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_in_kind   (i_s_axis_tuser),
        .o_in_ready  (o_s_axis_tready),
        .i_out_ready (i_m_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_status    (w_status),
        .o_op        (w_op)
    );

    // The datapath holds the table, the search bounds, the arithmetic and the result.
    tti_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (w_op),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .i_tdata     (i_s_axis_tdata),
        .o_status    (w_status),
        .o_result    (o_m_axis_tdata)
    );

endmodule

`default_nettype wire

// ===== dv/tti_result_checker.sv =====
// Checker that predicts every lookup temperature from the observed words and compares results.
`timescale 1ns / 1ps

module tti_result_checker #(
    parameter int TABLE_DEPTH = tti_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wen,
    input  logic [tti_pkg::LEN_W-1:0]            i_cfg_wdata,
    input  logic                                 i_in_tvalid,
    input  logic                                 i_in_tready,
    // tdata, lowest bit up: entry_index, entry_raw, entry_temp, raw_sample, zero pad.
    input  logic [tti_pkg::IN_TDATA_W-1:0]       i_in_tdata,
    // tuser: req_type.
    input  logic                                 i_in_tuser,
    input  logic                                 i_out_tvalid,
    input  logic                                 i_out_tready,
    // tdata, lowest bit up: temperature_q8.
    input  logic [tti_pkg::OUT_TDATA_W-1:0]      i_out_tdata,
    output int                                   o_mismatch_count,
    output int                                   o_pending
);

    logic signed [tti_pkg::RAW_W-1:0]    raw_col  [TABLE_DEPTH];
    logic signed [tti_pkg::TEMP_W-1:0]   temp_col [TABLE_DEPTH];
    logic [tti_pkg::LEN_W-1:0]           table_len;
    logic signed [tti_pkg::RESULT_W-1:0] pending_temps [$];
    int                                  mismatch_count;

    // Bisects the used part of the table and interpolates between the bracketing pair.
    function automatic logic signed [tti_pkg::RESULT_W-1:0] interpolate_temp(
        input logic signed [tti_pkg::RAW_W-1:0] sample
    );
        int unsigned len, lo, hi, mid;
        longint      s, r0, r1, t0, t1, width, q;
        bit          done;
        len  = (int'(table_len) > TABLE_DEPTH) ? TABLE_DEPTH : int'(table_len);
        lo   = 0;
        hi   = len;
        s    = sample;
        q    = longint'(temp_col[0]) * 256;
        done = 1'b0;
        for (int step = 0; step < 64 && !done; step++) begin
            mid = (lo + hi) >> 1;
            if (mid == 0) begin
                done = 1'b1;
            end else if (mid == lo || mid == hi) begin
                q    = longint'(temp_col[len-1]) * 256;
                done = 1'b1;
            end else begin
                r0 = raw_col[mid-1];
                r1 = raw_col[mid];
                if (s < r0) begin
                    hi = mid;
                end else if (s > r1) begin
                    lo = mid;
                end else begin
                    t0    = temp_col[mid-1];
                    t1    = temp_col[mid];
                    width = r1 - r0;
                    // Two equal raw readings give the lower temperature.
                    if (width == 0) begin
                        q = t0 * 256;
                    end else begin
                        q = ((t0 * width + (s - r0) * (t1 - t0)) * 256) / width;
                    end
                    done = 1'b1;
                end
            end
        end
        if (q > 64'sd8388607) begin
            q = 64'sd8388607;
        end
        if (q < -64'sd8388608) begin
            q = -64'sd8388608;
        end
        return q[tti_pkg::RESULT_W-1:0];
    endfunction

    always @(posedge i_clk) begin : monitor
        logic signed [tti_pkg::RESULT_W-1:0] want;
        logic signed [tti_pkg::RESULT_W-1:0] got;
        logic [tti_pkg::INDEX_W-1:0]         idx;
        if (!i_rst_n) begin
            table_len = tti_pkg::LEN_RESET;
            pending_temps.delete();
            mismatch_count = 0;
        end else begin
            if (i_cfg_wen) begin
                table_len = i_cfg_wdata;
            end
            if (i_in_tvalid && i_in_tready) begin
                if (i_in_tuser == tti_pkg::REQ_WRITE) begin
                    idx = i_in_tdata[tti_pkg::INDEX_LSB +: tti_pkg::INDEX_W];
                    if (int'(idx) < TABLE_DEPTH) begin
                        raw_col[idx]  = i_in_tdata[tti_pkg::ERAW_LSB +: tti_pkg::RAW_W];
                        temp_col[idx] = i_in_tdata[tti_pkg::ETEMP_LSB +: tti_pkg::TEMP_W];
                    end
                end else begin
                    pending_temps.push_back(
                        interpolate_temp(i_in_tdata[tti_pkg::SAMPLE_LSB +: tti_pkg::RAW_W]));
                end
            end
            if (i_out_tvalid && i_out_tready) begin
                got = i_out_tdata;
                if (pending_temps.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: temperature_q8 expected none, got %0d", $time, got);
                end else begin
                    want = pending_temps.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        $display("%0t: temperature_q8 expected %0d, got %0d", $time, want, got);
                    end
                end
            end
        end
        o_mismatch_count <= mismatch_count;
        o_pending        <= pending_temps.size();
    end

endmodule

// ===== dv/tb.sv =====
// Top of the thermistor table interpolator testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;

    import tti_pkg::*;

    // The run is far shorter than this; hitting it means the block hung.
    localparam int CYCLE_LIMIT = 400000;
    // This outlasts the longest lookup, so it covers any word still in flight.
    localparam int SETTLE_CYCLES = 64;
    localparam int PHASES = 12;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_wen;
    logic [LEN_W-1:0]        cfg_wdata;
    logic                    in_tvalid;
    logic                    in_tready;
    // tdata, lowest bit up: entry_index, entry_raw, entry_temp, raw_sample, zero pad.
    logic [IN_TDATA_W-1:0]   in_tdata;
    // tuser: req_type.
    logic                    in_tuser;
    logic                    out_tvalid;
    logic                    out_tready = 1'b0;
    // tdata, lowest bit up: temperature_q8.
    logic [OUT_TDATA_W-1:0]  out_tdata;

    int          mismatch_count;
    int          temps_pending;
    int unsigned cycle_count = 0;
    int          send_idle_pct = 26;
    int          recv_idle_pct = 55;

    // Raw readings as last written, used only to aim lookup samples at the table.
    int tab_raw [128];

    // Each random phase: table_length value, entries reloaded as a sorted table, lookups.
    // The lengths above 128 come right after the full load so that the whole table is
    // still sorted, but for stray rewrites, when they saturate to the full depth.
    int phase_len     [PHASES] = '{128, 255, 200, 0, 1, 2, 3, 5, 9, 17, 33, 2};
    int phase_load    [PHASES] = '{128, 0, 0, 1, 1, 2, 3, 5, 9, 17, 33, 2};
    int phase_lookups [PHASES] = '{50, 30, 25, 12, 12, 30, 30, 30, 30, 30, 40, 25};

    thermistor_table_interpolator dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_wen       (cfg_wen),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (in_tvalid),
        .o_s_axis_tready (in_tready),
        .i_s_axis_tdata  (in_tdata),
        .i_s_axis_tuser  (in_tuser),
        .o_m_axis_tvalid (out_tvalid),
        .i_m_axis_tready (out_tready),
        .o_m_axis_tdata  (out_tdata)
    );

    tti_result_checker temp_monitor (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_wen        (cfg_wen),
        .i_cfg_wdata      (cfg_wdata),
        .i_in_tvalid      (in_tvalid),
        .i_in_tready      (in_tready),
        .i_in_tdata       (in_tdata),
        .i_in_tuser       (in_tuser),
        .i_out_tvalid     (out_tvalid),
        .i_out_tready     (out_tready),
        .i_out_tdata      (out_tdata),
        .o_mismatch_count (mismatch_count),
        .o_pending        (temps_pending)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
    end

    // The receiver stalls at random with the probability of the current idling mode.
    always @(posedge clk) begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("thermistor_table_interpolator verification failed");
        $finish;
    end

    function automatic logic [15:0] rand16();
        logic [31:0] r;
        r = $urandom;
        return r[15:0];
    endfunction

    // Presents one word and holds it until it is accepted. The valid stays high when
    // the next word follows at once, so it is never lowered and raised in one step.
    task automatic send_word(input logic req, input logic [INDEX_W-1:0] idx,
                             input logic [RAW_W-1:0] eraw, input logic [TEMP_W-1:0] etemp,
                             input logic [RAW_W-1:0] sample);
        if ($urandom_range(99) < send_idle_pct) begin
            in_tvalid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_tvalid <= 1'b1;
        in_tuser  <= req;
        in_tdata  <= {1'b0, sample, etemp, eraw, idx};
        @(posedge clk);
        while (!in_tready) @(posedge clk);
    endtask

    // Writes one table entry; the unused sample field carries random bits.
    task automatic write_entry(input int idx, input int raw, input int temp);
        logic [31:0] i32, r32, t32;
        i32 = idx;
        r32 = raw;
        t32 = temp;
        tab_raw[idx] = raw;
        send_word(REQ_WRITE, i32[INDEX_W-1:0], r32[15:0], t32[15:0], rand16());
    endtask

    // Looks up one sample; the unused entry fields carry random bits.
    task automatic look_up(input int sample);
        logic [31:0] s32, i32;
        s32 = sample;
        i32 = $urandom;
        send_word(REQ_LOOKUP, i32[INDEX_W-1:0], rand16(), rand16(), s32[15:0]);
    endtask

    // Stops sending and waits until every expected result is back and the block is idle.
    task automatic drain_results();
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (temps_pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_table_length(input int len);
        logic [31:0] l32;
        l32 = len;
        drain_results();
        cfg_wen   <= 1'b1;
        cfg_wdata <= l32[LEN_W-1:0];
        @(posedge clk);
        cfg_wen   <= 1'b0;
    endtask

    // Loads entries 0..n-1 with ascending raw readings and random temperatures. About one
    // step in eight repeats the previous reading, which makes a zero-width bracket.
    task automatic load_table(input int n);
        int raw_acc, step_max;
        logic [15:0] t16;
        raw_acc  = -32768 + int'($urandom_range(2000));
        step_max = 63000 / ((n > 1) ? n - 1 : 1);
        for (int i = 0; i < n; i++) begin
            if (i > 0 && $urandom_range(7) != 0) begin
                raw_acc += int'($urandom_range(step_max));
            end
            if (raw_acc > 32767) begin
                raw_acc = 32767;
            end
            t16 = rand16();
            write_entry(i, raw_acc, int'($signed(t16)));
        end
    endtask

    // Picks a sample: mostly inside the table span, some exactly on an entry, some just
    // outside it, some at either end of the 16-bit range and the rest anywhere in it.
    function automatic int pick_sample(input int span);
        int lo_r, hi_r, pick;
        logic [15:0] r16;
        lo_r = tab_raw[0];
        hi_r = tab_raw[span-1];
        if (hi_r < lo_r) begin
            lo_r = tab_raw[span-1];
            hi_r = tab_raw[0];
        end
        pick = $urandom_range(99);
        r16  = rand16();
        if (pick < 60) begin
            return lo_r + int'($urandom_range(hi_r - lo_r));
        end else if (pick < 75) begin
            return tab_raw[$urandom_range(span - 1)];
        end else if (pick < 83) begin
            return (lo_r > -32768) ? lo_r - 1 : lo_r;
        end else if (pick < 90) begin
            return (hi_r < 32767) ? hi_r + 1 : hi_r;
        end else if (pick < 95) begin
            return ($urandom_range(1) == 0) ? -32768 : 32767;
        end
        return int'($signed(r16));
    endfunction

    initial begin
        int span, widx;
        logic [15:0] r16, t16;
        rst_n     <= 1'b0;
        cfg_wen   <= 1'b0;
        cfg_wdata <= '0;
        in_tvalid <= 1'b0;
        in_tuser  <= REQ_WRITE;
        in_tdata  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset length of two entries. First the widest bracket,
        // probed at both ends and around zero.
        write_entry(0, -32768, -32768);
        write_entry(1, 32767, 32767);
        look_up(-32768);
        look_up(32767);
        look_up(0);
        look_up(-1);
        look_up(1);
        // Highest index, then a zero-width bracket at the lowest raw reading.
        write_entry(127, 32767, -32768);
        write_entry(1, -32768, 32767);
        look_up(-32768);
        look_up(5);
        // A narrow falling bracket: below, above, on both ends and negative fractions.
        write_entry(0, 100, 25);
        write_entry(1, 200, -40);
        look_up(50);
        look_up(300);
        look_up(150);
        look_up(133);
        look_up(100);
        look_up(200);
        // Full-scale temperature swing over a tiny raw span.
        write_entry(0, -5, 32767);
        write_entry(1, 5, -32768);
        look_up(0);
        look_up(-4);

        // Random part. The first four phases run with the sender idling less than the
        // receiver, the next four the other way round, and the last four with no idling.
        for (int p = 0; p < PHASES; p++) begin
            if (p == 4) begin
                send_idle_pct = 55;
                recv_idle_pct = 26;
            end else if (p == 8) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            set_table_length(phase_len[p]);
            if (phase_load[p] > 0) begin
                load_table(phase_load[p]);
            end
            span = (phase_len[p] > 128) ? 128 : ((phase_len[p] < 1) ? 1 : phase_len[p]);
            for (int k = 0; k < phase_lookups[p]; k++) begin
                // Once in mid-phase, let the block run dry before sending more.
                if (p == 6 && k == phase_lookups[p] / 2) begin
                    drain_results();
                end
                if ($urandom_range(99) < 12) begin
                    // Stray rewrite, which may break the ordering of the table.
                    widx = ($urandom_range(1) == 0) ? int'($urandom_range(span - 1))
                                                    : int'($urandom_range(127));
                    r16 = rand16();
                    t16 = rand16();
                    write_entry(widx, int'($signed(r16)), int'($signed(t16)));
                end else begin
                    look_up(pick_sample(span));
                end
            end
        end

        drain_results();
        if (mismatch_count == 0 && temps_pending == 0) begin
            $display("thermistor_table_interpolator verification clean");
        end else begin
            $display("thermistor_table_interpolator verification failed");
        end
        $finish;
    end

endmodule
